>>> src/lphm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types, codes and hash constants for the linear probe hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_MOD,
        ST_RD,
        ST_CK,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       mix;
        logic       mod_step;
        logic       probe_check;
        logic       clear_step;
        logic       finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_clear;
        logic last_round;
        logic mod_done;
        logic ck_stop;
        logic sweep_done;
        logic init;
    } stat_t;

    localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_MUL2   = 64'h94d049bb133111eb;
    localparam int          HASH_SHR0   = 30;
    localparam int          HASH_SHR1   = 27;
    localparam int          HASH_SHR2   = 31;

    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_LH = 2'd1;
    localparam logic [1:0] MUL_HL = 2'd2;

    // Multiplier constant of each mixing round
    function automatic logic [63:0] round_const(input logic [1:0] round);
        logic [63:0] c;
        case (round)
            2'd0:    c = HASH_GOLDEN;
            2'd1:    c = HASH_MUL1;
            default: c = HASH_MUL2;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/linear_probe_hash_map_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// Fixed-capacity open-addressing hash map, 128-bit keys, 64-bit values.
// ----------------------------------------------------------------------------
// One request is in work at a time. A put, get or remove first hashes the key
// (three 64-bit multiplies, each three passes of one 32x32 multiplier, plus a
// mix step after each), then reduces it modulo SLOTS (a single step when SLOTS
// is a power of two; fold, quotient estimate and fix-up when it is not), then
// walks the probes (registered store read, then compare), then commits. A clear
// walks every slot, then commits. After reset the slot state is swept before
// s_ready rises. A finished result waits in the output register while the next
// request is taken.
module linear_probe_hash_map_unit
    import lphm_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [63:0] s_key_low,
    input  wire logic [63:0] s_key_high,
    input  wire logic [63:0] s_value_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_hit,
    output logic [63:0]      m_value_out,
    output logic [6:0]       m_entry_total
);

    cmd_t  cmd;
    stat_t stat;

    lphm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    lphm_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_operation(s_operation), .s_key_low(s_key_low),
        .s_key_high(s_key_high), .s_value_in(s_value_in),
        .m_status(m_status), .m_hit(m_hit),
        .m_value_out(m_value_out), .m_entry_total(m_entry_total)
    );

    // One request in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in work");

    // A hit always reports ok
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_status == STATUS_OK))
        else $error("hit with non-ok status");

    // Misses and refusals return no value
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_value_out == 64'd0))
        else $error("value returned without hit");

endmodule
`default_nettype wire

>>> src/lphm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/lphm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_ctrl
// Sequencer: hash rounds, modulo, probe walk, commit, clear sweep.
// ----------------------------------------------------------------------------
module lphm_ctrl
    import lphm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.sweep_done) state_next = stat.init ? ST_IDLE : ST_DONE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = stat.in_clear ? ST_CLEAR : ST_MUL0;
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MIX;
            ST_MIX: begin
                state_next = stat.last_round ? ST_MOD : ST_MUL0;
            end
            ST_MOD: begin
                if (stat.mod_done) state_next = ST_RD;
            end
            ST_RD: state_next = ST_CK;
            ST_CK: begin
                state_next = stat.ck_stop ? ST_DONE : ST_RD;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE:  cmd.load = s_valid;
            ST_MUL0: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LL;
            end
            ST_MUL1: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LH;
            end
            ST_MUL2: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_HL;
            end
            ST_MIX:  cmd.mix = 1'b1;
            ST_MOD:  cmd.mod_step = 1'b1;
            ST_CK:   cmd.probe_check = 1'b1;
            ST_DONE: cmd.finish = out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/lphm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_datapath
// Request registers, serial hash and modulo, slot stores, probe and commit.
// ----------------------------------------------------------------------------
module lphm_datapath
    import lphm_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [1:0]  s_operation,
    input  wire logic [63:0] s_key_low,
    input  wire logic [63:0] s_key_high,
    input  wire logic [63:0] s_value_in,
    output logic      [1:0]  m_status,
    output logic             m_hit,
    output logic      [63:0] m_value_out,
    output logic      [6:0]  m_entry_total
);

    localparam int AW      = $clog2(SLOTS);
    localparam int CW      = $clog2(SLOTS / 2 + 1);
    localparam int YW      = AW + 18;
    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [AW:0]   SLOTS_W   = (AW + 1)'(SLOTS);
    localparam logic [CW-1:0] HALF_W    = CW'(SLOTS / 2);
    // Weights of the upper 16-bit chunks modulo SLOTS, and the reciprocal
    localparam logic [AW-1:0] FOLD1 = AW'((64'd1 << 16) % 64'(SLOTS));
    localparam logic [AW-1:0] FOLD2 = AW'((64'd1 << 32) % 64'(SLOTS));
    localparam logic [AW-1:0] FOLD3 = AW'((64'd1 << 48) % 64'(SLOTS));
    localparam logic [YW-1:0] RECIP = YW'((64'd1 << YW) / 64'(SLOTS));

    // Request registers
    op_t         op_reg;
    logic [63:0] klo_reg, khi_reg, vin_reg;

    // Hash state
    logic [63:0] x_reg, acc_reg;
    logic [1:0]  round_reg;
    logic [1:0]  mb_reg;
    logic [YW-1:0] y_reg, q_reg;

    // Probe state
    logic [AW-1:0] pos_reg, n_reg, found_pos_reg, free_pos_reg, clr_cnt_reg;
    logic          found_reg, free_reg, init_reg;
    logic [63:0]   vfound_reg;
    logic [CW-1:0] live_reg;

    // Store read data
    logic [63:0] klo_rd, khi_rd, val_rd;
    logic [1:0]  mark_rd;

    // ---------------- hash multiply, 32x32 partial products ----------------
    logic [63:0] mconst;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    assign mconst = round_const(round_reg);

    always_comb begin
        case (cmd.mul_phase)
            MUL_LL: begin
                ma = x_reg[31:0];
                mb = mconst[31:0];
            end
            MUL_LH: begin
                ma = x_reg[31:0];
                mb = mconst[63:32];
            end
            default: begin
                ma = x_reg[63:32];
                mb = mconst[31:0];
            end
        endcase
    end

    assign prod = 64'(ma) * 64'(mb);

    // Xor-shift step of each round
    logic [63:0] t0, mix_val;
    always_comb begin
        t0 = klo_reg ^ acc_reg;
        case (round_reg)
            2'd0:    mix_val = t0 ^ (t0 >> HASH_SHR0);
            2'd1:    mix_val = acc_reg ^ (acc_reg >> HASH_SHR1);
            default: mix_val = acc_reg ^ (acc_reg >> HASH_SHR2);
        endcase
    end

    // ---------------- modulo: chunk fold, reciprocal estimate, fix-up ----------------
    // The 16-bit chunks are folded with their weights mod SLOTS; the quotient
    // estimate from the reciprocal is low by at most one, so one subtract fixes it.
    logic [YW-1:0]   fold_sum, q_est, q_times, rem_full;
    logic [2*YW-1:0] recip_prod;
    logic [AW:0]     rem_low, rem_step;
    assign fold_sum   = YW'(x_reg[15:0])
                      + YW'(x_reg[31:16]) * YW'(FOLD1)
                      + YW'(x_reg[47:32]) * YW'(FOLD2)
                      + YW'(x_reg[63:48]) * YW'(FOLD3);
    assign recip_prod = (2 * YW)'(y_reg) * (2 * YW)'(RECIP);
    assign q_est      = recip_prod[2*YW-1:YW];
    assign q_times    = q_reg * YW'(SLOTS);
    assign rem_full   = y_reg - q_times;
    assign rem_low    = rem_full[AW:0];
    assign rem_step   = (rem_low >= SLOTS_W) ? rem_low - SLOTS_W : rem_low;

    // ---------------- probe check ----------------
    mark_t mark_cur;
    logic  key_match, stop;
    assign mark_cur  = mark_t'(mark_rd);
    assign key_match = (mark_cur == MARK_LIVE) && (klo_rd == klo_reg) && (khi_rd == khi_reg);
    assign stop      = (mark_cur == MARK_EMPTY) || key_match || (n_reg == LAST_SLOT);

    // ---------------- commit decisions ----------------
    logic full;
    logic put_new, put_upd, do_remove;
    assign full      = (live_reg >= HALF_W);
    assign put_upd   = (op_reg == OP_PUT) && found_reg;
    assign put_new   = (op_reg == OP_PUT) && !found_reg && !full;
    assign do_remove = (op_reg == OP_REMOVE) && found_reg;

    status_t     res_status;
    logic        res_hit;
    logic [63:0] res_val;
    always_comb begin
        res_status = STATUS_OK;
        res_hit    = 1'b0;
        res_val    = '0;
        case (op_reg)
            OP_PUT: begin
                if (found_reg)  res_hit = 1'b1;
                else if (full)  res_status = STATUS_FULL;
            end
            OP_GET, OP_REMOVE: begin
                if (found_reg) begin
                    res_hit = 1'b1;
                    res_val = vfound_reg;
                end else begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            default: res_status = STATUS_OK;
        endcase
    end

    // ---------------- slot stores ----------------
    logic          key_we, val_we, mark_we;
    logic [AW-1:0] val_waddr, mark_waddr;
    logic [1:0]    mark_wdata;

    assign key_we    = cmd.finish && put_new;
    assign val_we    = cmd.finish && (put_new || put_upd);
    assign val_waddr = put_upd ? found_pos_reg : free_pos_reg;

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = free_pos_reg;
        mark_wdata = MARK_LIVE;
        if (cmd.clear_step) begin
            mark_we    = 1'b1;
            mark_waddr = clr_cnt_reg;
            mark_wdata = MARK_EMPTY;
        end else if (cmd.finish && put_new) begin
            mark_we = 1'b1;
        end else if (cmd.finish && do_remove) begin
            mark_we    = 1'b1;
            mark_waddr = found_pos_reg;
            mark_wdata = MARK_TOMB;
        end
    end

    lphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_low (
        .aclk(aclk), .we(key_we), .waddr(free_pos_reg), .wdata(klo_reg),
        .raddr(pos_reg), .rdata(klo_rd)
    );
    lphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_high (
        .aclk(aclk), .we(key_we), .waddr(free_pos_reg), .wdata(khi_reg),
        .raddr(pos_reg), .rdata(khi_rd)
    );
    lphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_value (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(vin_reg),
        .raddr(pos_reg), .rdata(val_rd)
    );
    lphm_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
        .aclk(aclk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(pos_reg), .rdata(mark_rd)
    );

    // ---------------- status ----------------
    assign stat.in_clear   = (op_t'(s_operation) == OP_CLEAR);
    assign stat.last_round = (round_reg == 2'd2);
    assign stat.mod_done   = IS_POW2 || (mb_reg == 2'd2);
    assign stat.ck_stop    = stop;
    assign stat.sweep_done = (clr_cnt_reg == LAST_SLOT);
    assign stat.init       = init_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            clr_cnt_reg <= '0;
            init_reg    <= 1'b1;
        end else begin
            if (cmd.clear_step) begin
                if (clr_cnt_reg == LAST_SLOT) begin
                    clr_cnt_reg <= '0;
                    init_reg    <= 1'b0;
                end else begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            if (cmd.load && stat.in_clear) begin
                live_reg <= '0;
            end else if (cmd.finish && put_new) begin
                live_reg <= live_reg + 1'b1;
            end else if (cmd.finish && do_remove) begin
                live_reg <= live_reg - 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= op_t'(s_operation);
            klo_reg   <= s_key_low;
            khi_reg   <= s_key_high;
            vin_reg   <= s_value_in;
            x_reg     <= s_key_high;
            round_reg <= 2'd0;
            mb_reg    <= '0;
            n_reg     <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        if (cmd.mul_en) begin
            if (cmd.mul_phase == MUL_LL) acc_reg <= prod;
            else acc_reg <= acc_reg + {prod[31:0], 32'd0};
        end
        if (cmd.mix) begin
            x_reg     <= mix_val;
            round_reg <= round_reg + 2'd1;
        end
        if (cmd.mod_step) begin
            if (!IS_POW2) begin
                if (mb_reg == 2'd0) y_reg <= fold_sum;
                if (mb_reg == 2'd1) q_reg <= q_est;
                mb_reg <= mb_reg + 2'd1;
            end
            if (stat.mod_done) begin
                pos_reg <= IS_POW2 ? x_reg[AW-1:0] : rem_step[AW-1:0];
            end
        end
        if (cmd.probe_check) begin
            if (key_match) begin
                found_reg     <= 1'b1;
                found_pos_reg <= pos_reg;
                vfound_reg    <= val_rd;
            end else if (mark_cur != MARK_LIVE && !free_reg) begin
                free_reg     <= 1'b1;
                free_pos_reg <= pos_reg;
            end
            if (!stop) begin
                pos_reg <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
                n_reg   <= n_reg + 1'b1;
            end
        end
    end

    // ---------------- result register ----------------
    logic [CW+6:0] total_ext;
    always_comb begin
        total_ext = '0;
        if (op_reg == OP_CLEAR)   total_ext = '0;
        else if (put_new)         total_ext = (CW + 7)'(live_reg) + 1'b1;
        else if (do_remove)       total_ext = (CW + 7)'(live_reg) - 1'b1;
        else                      total_ext = (CW + 7)'(live_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_status      <= res_status;
            m_hit         <= res_hit;
            m_value_out   <= res_val;
            m_entry_total <= total_ext[6:0];
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives put, get, remove and clear requests into the hash map. A software
// copy of the table predicts every response, and a scoreboard compares the
// responses in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lphm_pkg::*;

    localparam int NSLOT = 64;
    localparam int IDLE_LIMIT = 4000;

    // One expected response
    typedef struct {
        status_t     status;
        logic        hit;
        logic [63:0] value;
        logic [6:0]  total;
    } resp_t;

    // Response store and field compare
    class map_scoreboard;
        resp_t pending[$];
        int    errors;
        int    checked;

        function void note_request(resp_t r);
            pending.push_back(r);
        endfunction

        task automatic report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task automatic check_response(logic [1:0] st, logic h, logic [63:0] v,
                                      logic [6:0] t);
            resp_t e;
            if (pending.size() == 0) begin
                report("response with nothing pending");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (h !== e.hit)
                report($sformatf("hit %0d, want %0d", h, e.hit));
            if (v !== e.value)
                report($sformatf("value %h, want %h", v, e.value));
            if (t !== e.total)
                report($sformatf("entry total %0d, want %0d", t, e.total));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = 2'd0;
    logic [63:0] s_key_low = '0;
    logic [63:0] s_key_high = '0;
    logic [63:0] s_value_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_hit;
    logic [63:0] m_value_out;
    logic [6:0]  m_entry_total;

    linear_probe_hash_map_unit #(.SLOTS(NSLOT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_key_low(s_key_low), .s_key_high(s_key_high), .s_value_in(s_value_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_hit(m_hit),
        .m_value_out(m_value_out), .m_entry_total(m_entry_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted table contents
    logic [63:0] tbl_klo[NSLOT];
    logic [63:0] tbl_khi[NSLOT];
    logic [63:0] tbl_val[NSLOT];
    mark_t       tbl_mark[NSLOT];
    int          tbl_live;

    // Key pool so gets and removes mostly hit stored keys
    logic [63:0] pool_lo[16];
    logic [63:0] pool_hi[16];

    map_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;
    int n_sent = 0;
    int n_full = 0;
    int n_miss = 0;

    function automatic int slot_of(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] x;
        x = lo ^ (hi * HASH_GOLDEN);
        x = x ^ (x >> 30);
        x = x * HASH_MUL1;
        x = x ^ (x >> 27);
        x = x * HASH_MUL2;
        x = x ^ (x >> 31);
        return int'(x % NSLOT);
    endfunction

    function automatic int find_key(logic [63:0] lo, logic [63:0] hi);
        int p;
        p = slot_of(lo, hi);
        for (int n = 0; n < NSLOT; n++) begin
            if (tbl_mark[p] == MARK_EMPTY)
                return -1;
            if (tbl_mark[p] == MARK_LIVE && tbl_klo[p] == lo && tbl_khi[p] == hi)
                return p;
            p = (p + 1) % NSLOT;
        end
        return -1;
    endfunction

    // Apply one request to the predicted table
    function automatic resp_t apply_request(op_t op, logic [63:0] lo,
                                            logic [63:0] hi, logic [63:0] v);
        resp_t r;
        int f;
        int p;
        r.status = STATUS_OK;
        r.hit = 1'b0;
        r.value = '0;
        if (op == OP_CLEAR) begin
            foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
            tbl_live = 0;
        end else begin
            f = find_key(lo, hi);
            if (op == OP_PUT) begin
                if (f >= 0) begin
                    tbl_val[f] = v;
                    r.hit = 1'b1;
                end else if ((tbl_live + 1) * 2 > NSLOT) begin
                    r.status = STATUS_FULL;
                end else begin
                    p = slot_of(lo, hi);
                    while (tbl_mark[p] == MARK_LIVE) p = (p + 1) % NSLOT;
                    tbl_klo[p] = lo;
                    tbl_khi[p] = hi;
                    tbl_val[p] = v;
                    tbl_mark[p] = MARK_LIVE;
                    tbl_live++;
                end
            end else if (f < 0) begin
                r.status = STATUS_NOT_FOUND;
            end else begin
                r.hit = 1'b1;
                r.value = tbl_val[f];
                if (op == OP_REMOVE) begin
                    tbl_mark[f] = MARK_TOMB;
                    tbl_live--;
                end
            end
        end
        r.total = tbl_live[6:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Present one request and hold it until accepted; valid drops only to idle
    task automatic send_request(op_t op, logic [63:0] lo, logic [63:0] hi,
                                logic [63:0] v);
        resp_t r;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_key_low <= lo;
        s_key_high <= hi;
        s_value_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_request(op, lo, hi, v);
        if (r.status == STATUS_FULL) n_full++;
        if (r.status == STATUS_NOT_FOUND) n_miss++;
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Random request, mostly on pooled keys
    task automatic random_request();
        int k;
        int pick;
        logic [63:0] lo;
        logic [63:0] hi;
        k = $urandom_range(15);
        lo = pool_lo[k];
        hi = pool_hi[k];
        if ($urandom_range(9) == 0) begin
            lo = rand64();
            hi = rand64();
        end
        pick = $urandom_range(99);
        if (pick < 45) send_request(OP_PUT, lo, hi, rand64());
        else if (pick < 75) send_request(OP_GET, lo, hi, '0);
        else if (pick < 99) send_request(OP_REMOVE, lo, hi, rand64());
        else send_request(OP_CLEAR, lo, hi, rand64());
    endtask

    // Response side: random stall, compare on acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_response(m_status, m_hit, m_value_out, m_entry_total);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any acceptance
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT + 20 * NSLOT) begin
            $display("watchdog: no progress, %0d responses pending",
                     sb.pending.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
        tbl_live = 0;
        foreach (pool_lo[i]) begin
            pool_lo[i] = rand64();
            pool_hi[i] = rand64();
        end
        pool_lo[0] = '0;
        pool_hi[0] = '0;
        pool_lo[1] = '1;
        pool_hi[1] = '1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 12;
        recv_idle = 58;

        // Directed: misses on empty table, extremes, update, remove, clear
        send_request(OP_GET, '0, '0, '0);
        send_request(OP_REMOVE, '1, '1, '0);
        send_request(OP_PUT, '0, '0, '1);
        send_request(OP_PUT, '1, '1, '0);
        send_request(OP_PUT, '1, '0, 64'h5555_5555_5555_5555);
        send_request(OP_PUT, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_GET, '0, '0, '1);
        send_request(OP_GET, '1, '1, '0);
        send_request(OP_REMOVE, '1, '0, '0);
        send_request(OP_GET, '1, '0, '0);
        send_request(OP_REMOVE, '1, '0, '0);
        send_request(OP_PUT, '1, '0, 64'h1234);
        send_request(OP_CLEAR, '1, '1, '1);
        send_request(OP_GET, '0, '0, '0);
        // Fill to the half-capacity limit, then one more is refused
        for (int i = 0; i < NSLOT / 2 + 1; i++)
            send_request(OP_PUT, rand64(), rand64(), rand64());
        send_request(OP_GET, rand64(), rand64(), '0);

        // Pause until every response is back
        drain();
        send_request(OP_CLEAR, '0, '0, '0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 12 : (ph == 1) ? 58 : 0;
            recv_idle = (ph == 0) ? 58 : (ph == 1) ? 12 : 0;
            for (int i = 0; i < 660; i++) begin
                // Occasionally refresh pool with fresh keys for load churn
                if ($urandom_range(31) == 0) begin
                    pool_lo[$urandom_range(15)] = rand64();
                    pool_hi[$urandom_range(15)] = rand64();
                end
                // Bursts of fresh puts push the table to full with tombstones
                if ($urandom_range(199) == 0)
                    repeat ($urandom_range(40)) send_request(OP_PUT, rand64(),
                                                             rand64(), rand64());
                random_request();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("Covered %0d requests: %0d checked, %0d refused full, %0d misses.",
                 n_sent, sb.checked, n_full, n_miss);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> linear_probe_hash_map_unit.f
src/lphm_pkg.sv
src/lphm_ram.sv
src/lphm_ctrl.sv
src/lphm_datapath.sv
src/linear_probe_hash_map_unit.sv
tb/tb_top.sv
